// ----- hw/rtl/murmur2_hash_stream_macros.svh -----
// assertion macros shared by the murmur2 hash stream rtl
`ifndef MURMUR2_HASH_STREAM_MACROS_SVH
`define MURMUR2_HASH_STREAM_MACROS_SVH

// same-cycle implication, checked outside reset
`define MH2_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mh2 same-cycle check failed");

// next-cycle implication, checked outside reset
`define MH2_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mh2 next-cycle check failed");

`endif

// ----- hw/rtl/mh2_pkg.sv -----
// shared types, constants and functions of the murmur2 hash stream
`timescale 1ns / 1ps
`default_nettype none
package mh2_pkg;

   localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
   localparam int          MIX_SHIFT  = 24;
   localparam int          AVAL_SHIFT_A = 13;
   localparam int          AVAL_SHIFT_B = 15;
   localparam logic [31:0] SEED_RESET = 32'd5381;
   localparam logic [30:0] LEN_MAX    = 31'h7fffffff;
   localparam logic [2:0]  FULL_COUNT = 3'd4;

   // register indexes of the csr port
   localparam logic CSR_SEED = 1'b0;
   localparam logic CSR_FOLD = 1'b1;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // one classified request word
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  count;
      logic        first;
      logic [31:0] init_hash;
      logic [30:0] stated_len;
      logic        last;
   } mh2_entry_type;

   // back-end status seen by the top level
   typedef struct packed {
      logic busy;
      logic pop;
      logic result_load;
   } mh2_status_type;

   // low 32 bits of value times the mixing constant
   function automatic logic [31:0] mul_mix(input logic [31:0] a);
      logic [63:0] p;
      p = a * MIX_MUL;
      return p[31:0];
   endfunction

   // ascii upper to lower case on each byte
   function automatic logic [31:0] fold_word(input logic [31:0] w);
      logic [31:0] r;
      logic [7:0]  b;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         b = w[8*i +: 8];
         if (b >= 8'h41 && b <= 8'h5a) begin
            b = b + 8'h20;
         end
         r[8*i +: 8] = b;
      end
      return r;
   endfunction

   // byte mask for a one to three byte tail
   function automatic logic [31:0] tail_mask(input logic [2:0] cnt);
      logic [31:0] m;
      case (cnt)
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/murmur2_hash_stream.sv -----
// murmur2 hash stream: a full word passes the back-end sequencer through KMUL, KMIX and HMUL,
// a tail word through TAIL, both on one shared multiplier
// the final word adds avalanche and result load; a 2-entry queue lets requests
// keep arriving while the back end works
// synchronous active-high reset clears queue, sequencer and message state; seed resets to 5381
`timescale 1ns / 1ps
`default_nettype none
`include "murmur2_hash_stream_macros.svh"
module murmur2_hash_stream
   import mh2_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [71:0]   req_tdata,   // data_word, byte_count, message_length, pad
   input  wire logic          req_tlast,
   // result channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // hash_value[31:0]
   output logic               rsp_tuser,   // length_mismatch[0]
   // csr write port
   input  wire logic          csr_we,
   input  wire logic          csr_addr,
   input  wire logic [31:0]   csr_wdata
);

   mh2_entry_type              push_entry;
   mh2_entry_type              head;
   mh2_status_type             status;
   logic                       q_push;
   logic                       q_pop;
   logic                       q_full;
   logic                       q_valid;
   logic [QUEUE_CNT_W-1:0]     q_count;

   // classify incoming requests
   mh2_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .data_word      (req_tdata[31:0]),
      .byte_count     (req_tdata[34:32]),
      .message_length (req_tdata[65:35]),
      .last_word      (req_tlast),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_entry        (push_entry)
   );

   // decoupling queue
   mh2_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (head),
      .count      (q_count)
   );

   // mixing and result
   mh2_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_head       (head),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_hash     (rsp_tdata),
      .out_mismatch (rsp_tuser),
      .status       (status)
   );

   // checks
   `MH2_ASSERT_IMP(a_pop_only_idle, clock, reset, status.pop, !status.busy && q_valid)
   `MH2_ASSERT_NXT(a_pop_starts_work, clock, reset,
                   status.pop && (head.count != 3'd0 || head.last), status.busy)
   `MH2_ASSERT_NXT(a_load_shows_result, clock, reset, status.result_load, rsp_tvalid)
   `MH2_ASSERT_IMP(a_queue_bound, clock, reset, q_count != '0,
                   q_valid && q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))

endmodule
`default_nettype wire

// ----- hw/rtl/mh2_front.sv -----
// front end: csr registers, case folding and request classification
`timescale 1ns / 1ps
`default_nettype none
module mh2_front
   import mh2_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire logic          csr_addr,
   input  wire logic [31:0]   csr_wdata,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [31:0]   data_word,
   input  wire logic [2:0]    byte_count,
   input  wire logic [30:0]   message_length,
   input  wire logic          last_word,
   input  wire logic          q_full,
   output logic               q_push,
   output mh2_entry_type      q_entry
);

   logic [31:0] seed_ff, seed_in;
   logic        fold_ff, fold_in;
   logic        in_msg_ff, in_msg_in;
   logic [2:0]  cnt_eff;

   // csr writes
   always_comb begin
      seed_in = seed_ff;
      fold_in = fold_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_SEED: seed_in = csr_wdata;
            CSR_FOLD: fold_in = csr_wdata[0];
            default:  ;
         endcase
      end
   end

   // accept whenever the queue has room
   assign in_ready = !q_full;
   assign q_push   = in_valid && in_ready;

   // non-last words and oversize counts mix as full words
   assign cnt_eff = (!last_word || byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;

   // classified request
   always_comb begin
      q_entry.word       = fold_ff ? fold_word(data_word) : data_word;
      q_entry.count      = cnt_eff;
      q_entry.first      = !in_msg_ff;
      q_entry.init_hash  = seed_ff ^ {1'b0, message_length};
      q_entry.stated_len = message_length;
      q_entry.last       = last_word;
   end

   // message tracking
   always_comb begin
      in_msg_in = in_msg_ff;
      if (q_push) begin
         in_msg_in = !last_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= SEED_RESET;
         fold_ff   <= 1'b0;
         in_msg_ff <= 1'b0;
      end else begin
         seed_ff   <= seed_in;
         fold_ff   <= fold_in;
         in_msg_ff <= in_msg_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mh2_queue.sv -----
// short request queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module mh2_queue
   import mh2_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  mh2_entry_type               push_entry,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        valid,
   output mh2_entry_type               head,
   output logic [QUEUE_CNT_W-1:0]      count
);

   mh2_entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;

   assign full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mh2_back.sv -----
// back end: mixing sequencer on one shared multiplier and result register
`timescale 1ns / 1ps
`default_nettype none
module mh2_back
   import mh2_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          q_valid,
   input  mh2_entry_type      q_head,
   output logic               q_pop,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [31:0]        out_hash,
   output logic               out_mismatch,
   output mh2_status_type     status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_KMUL = 3'd1;
   localparam logic [2:0] ST_KMIX = 3'd2;
   localparam logic [2:0] ST_HMUL = 3'd3;
   localparam logic [2:0] ST_TAIL = 3'd4;
   localparam logic [2:0] ST_AVAL = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] word_ff, word_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [30:0] bytes_ff, bytes_in;
   logic [30:0] stated_ff, stated_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_hash_ff, out_hash_in;
   logic        out_mis_ff, out_mis_in;
   logic [31:0] mul_a;
   logic [31:0] mul_p;
   logic [30:0] bytes_base;
   logic [30:0] room;
   logic [31:0] fin;
   logic        out_free;

   // shared multiplier operand
   always_comb begin
      case (state_ff)
         ST_KMUL: mul_a = word_ff;
         ST_KMIX: mul_a = k_ff ^ (k_ff >> MIX_SHIFT);
         ST_HMUL: mul_a = acc_ff;
         ST_TAIL: mul_a = acc_ff ^ (word_ff & tail_mask(cnt_ff));
         ST_AVAL: mul_a = acc_ff ^ (acc_ff >> AVAL_SHIFT_A);
         default: mul_a = acc_ff;
      endcase
   end

   assign mul_p = mul_mix(mul_a);

   // saturating byte count on the popped word
   assign bytes_base = q_head.first ? '0 : bytes_ff;
   assign room       = LEN_MAX - bytes_base;

   // final xorshift
   assign fin      = acc_ff ^ (acc_ff >> AVAL_SHIFT_B);
   assign out_free = !out_valid_ff || out_ready;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      word_in      = word_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      bytes_in     = bytes_ff;
      stated_in    = stated_ff;
      out_hash_in  = out_hash_ff;
      out_mis_in   = out_mis_ff;
      out_valid_in = out_valid_ff && !out_ready;
      q_pop        = 1'b0;
      status.busy        = (state_ff != ST_IDLE);
      status.result_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               acc_in    = q_head.first ? q_head.init_hash : acc_ff;
               stated_in = q_head.first ? q_head.stated_len : stated_ff;
               bytes_in  = ({28'd0, q_head.count} > room) ? LEN_MAX
                           : bytes_base + {28'd0, q_head.count};
               word_in   = q_head.word;
               cnt_in    = q_head.count;
               last_in   = q_head.last;
               if (q_head.count == FULL_COUNT) begin
                  state_in = ST_KMUL;
               end else if (q_head.count != 3'd0) begin
                  state_in = ST_TAIL;
               end else if (q_head.last) begin
                  state_in = ST_AVAL;
               end
            end
         end
         ST_KMUL: begin
            k_in     = mul_p;
            state_in = ST_KMIX;
         end
         ST_KMIX: begin
            k_in     = mul_p;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            acc_in   = mul_p ^ k_ff;
            state_in = last_ff ? ST_AVAL : ST_IDLE;
         end
         ST_TAIL: begin
            acc_in   = mul_p;
            state_in = last_ff ? ST_AVAL : ST_IDLE;
         end
         ST_AVAL: begin
            acc_in   = mul_p;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               status.result_load = 1'b1;
               out_valid_in = 1'b1;
               out_hash_in  = (stated_ff == '0) ? '0 : fin;
               out_mis_in   = (bytes_ff != stated_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      status.pop = q_pop;
   end

   assign out_valid    = out_valid_ff;
   assign out_hash     = out_hash_ff;
   assign out_mismatch = out_mis_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      k_ff        <= k_in;
      word_ff     <= word_in;
      cnt_ff      <= cnt_in;
      last_ff     <= last_in;
      bytes_ff    <= bytes_in;
      stated_ff   <= stated_in;
      out_hash_ff <= out_hash_in;
      out_mis_ff  <= out_mis_in;
   end

endmodule
`default_nettype wire
